### design/cpc_pkg.sv
package cpc_pkg;

    // Field widths
    localparam int IDX_W    = 10;
    localparam int LEN_W    = 11;
    localparam int STEP_W   = 32;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 3;

    // Largest table size that the index fields can address
    localparam int IDX_SPAN = 1 << IDX_W;

    // Packed stream widths
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 16;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_INIT    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SHUFFLE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_WALK    = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_SWAP  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_COMPLETE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_START = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_INIT   = 3'd4;

endpackage

### design/cpc_ram.sv
module cpc_ram
    #(
        parameter int WIDTH = 10,
        parameter int DEPTH = 1024
    )
    (
        input  logic                     clk,
        input  logic                     we,
        input  logic [$clog2(DEPTH)-1:0] waddr,
        input  logic [WIDTH-1:0]         wdata,
        input  logic [$clog2(DEPTH)-1:0] raddr,
        output logic [WIDTH-1:0]         rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/cpc_mod.sv
module cpc_mod
    import cpc_pkg::*;
    (
        input  logic              clk,
        input  logic              rst_n,
        input  logic              start,
        input  logic [STEP_W-1:0] dividend,
        input  logic [LEN_W-1:0]  divisor,
        output logic              done,
        output logic [LEN_W-1:0]  remainder
    );

    localparam int CNT_W = $clog2(STEP_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [STEP_W-1:0] dvd_reg;
    logic [LEN_W-1:0]  rem_reg;
    logic [LEN_W:0]    trial;
    logic [LEN_W:0]    diff;

    // One restoring step: shift in the next dividend bit and try a subtract
    assign trial = {rem_reg, dvd_reg[STEP_W-1]};
    assign diff  = trial - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            // Flag the last step for one cycle
            done_reg <= !start && busy_reg && (cnt_reg == CNT_W'(STEP_W - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEP_W - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Partial remainder and dividend shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[STEP_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
            begin
                rem_reg <= diff[LEN_W-1:0];
            end
            else
            begin
                rem_reg <= trial[LEN_W-1:0];
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

### design/cyclic_permutation_pointer_chase.sv
// Sequence: init writes each of the min(TABLE_DEPTH,1024) table entries in turn, a shuffle reads
// the two entries and writes them back swapped, and a walk makes one table read per step through
// the one registered read port: up to 2*L reads around the cycle of length L, plus a pass through
// the bit-serial remainder unit when the step count passes L.
// Throughput: one request at a time; the next is taken while a result waits at the output.
// Reset: async active low clears control state; table contents are undefined until an init.
module cyclic_permutation_pointer_chase
    import cpc_pkg::*;
    #(
        parameter int TABLE_DEPTH = 1024
    )
    (
        input  logic                  clk,
        input  logic                  rst_n,
        input  logic                  cfg_we,
        input  logic [LEN_W-1:0]      cfg_wdata,       // walk_length
        input  logic                  s_axis_tvalid,
        output logic                  s_axis_tready,
        // swap_target[9:0], start_index[19:10], step_count[51:20], zero pad
        input  logic [IN_DATA_W-1:0]  s_axis_tdata,
        input  logic [REQ_W-1:0]      s_axis_tuser,    // req_type[1:0]
        output logic                  m_axis_tvalid,
        input  logic                  m_axis_tready,
        // final_index[9:0], shuffle_done[10], zero pad
        output logic [OUT_DATA_W-1:0] m_axis_tdata,
        output logic [STATUS_W-1:0]   m_axis_tuser     // status[2:0]
    );

    localparam int MEM_DEPTH = (TABLE_DEPTH > IDX_SPAN) ? IDX_SPAN : TABLE_DEPTH;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int LEN_RST   = (1024 > TABLE_DEPTH) ? TABLE_DEPTH : 1024;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_INIT    = 9'b000000010,
        S_SH_RD_B = 9'b000000100,
        S_SH_WR_A = 9'b000001000,
        S_SH_WR_B = 9'b000010000,
        S_WK_CHK  = 9'b000100000,
        S_WK_WAIT = 9'b001000000,
        S_WK_MOD  = 9'b010000000,
        S_RESP    = 9'b100000000
    } state_t;

    state_t             state_reg;
    state_t             state_next;

    logic [LEN_W-1:0]   len_reg;
    logic [LEN_W-1:0]   pos_reg;
    logic               loaded_reg;
    logic               m_valid_reg;

    logic [IDX_W-1:0]   target_reg;
    logic [IDX_W-1:0]   start_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   a_reg;
    logic [STEP_W-1:0]  steps_reg;
    logic [LEN_W-1:0]   t_reg;
    logic               phase_reg;
    logic [AW-1:0]      init_cnt_reg;
    logic [IDX_W-1:0]   fin_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [IDX_W-1:0]   out_fin_reg;
    logic               out_done_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic [IDX_W-1:0]   in_target;
    logic [IDX_W-1:0]   in_start;
    logic [STEP_W-1:0]  in_steps;
    logic               in_xfer;
    logic               out_free;
    logic [LEN_W-1:0]   len_m1;
    logic               shuf_full;
    logic               swap_bad;
    logic               start_bad;
    logic [STATUS_W-1:0] in_status;
    logic               wk_hit;
    logic               wk_wrap;
    logic [LEN_W-1:0]   cfg_len;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [IDX_W-1:0]   mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [IDX_W-1:0]   mem_rdata;

    logic               mod_start;
    logic               mod_done;
    logic [LEN_W-1:0]   mod_rem;

    // Unpack input fields
    assign in_target = s_axis_tdata[IDX_W-1:0];
    assign in_start  = s_axis_tdata[2*IDX_W-1:IDX_W];
    assign in_steps  = s_axis_tdata[2*IDX_W+STEP_W-1:2*IDX_W];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    // Clamp the written length into 2..TABLE_DEPTH
    always_comb
    begin
        if (cfg_wdata < LEN_W'(2))
        begin
            cfg_len = LEN_W'(2);
        end
        else if (32'(cfg_wdata) > TABLE_DEPTH)
        begin
            cfg_len = LEN_W'(TABLE_DEPTH);
        end
        else
        begin
            cfg_len = cfg_wdata;
        end
    end

    // Request checks
    assign len_m1    = len_reg - 1'b1;
    assign shuf_full = (pos_reg >= len_m1);
    assign swap_bad  = (LEN_W'(in_target) <= pos_reg) || (LEN_W'(in_target) > len_m1);
    assign start_bad = (LEN_W'(in_start) >= len_reg);

    // Status of the request on the input
    always_comb
    begin
        in_status = ST_OK;
        case (s_axis_tuser)
            REQ_SHUFFLE:
            begin
                if (!loaded_reg)
                begin
                    in_status = ST_NO_INIT;
                end
                else if (shuf_full)
                begin
                    in_status = ST_COMPLETE;
                end
                else if (swap_bad)
                begin
                    in_status = ST_BAD_SWAP;
                end
            end
            REQ_WALK:
            begin
                if (!loaded_reg)
                begin
                    in_status = ST_NO_INIT;
                end
                else if (start_bad)
                begin
                    in_status = ST_BAD_START;
                end
            end
            default:
            begin
                in_status = ST_OK;
            end
        endcase
    end

    // Walk checks: step count reached, or back at the start of the cycle
    assign wk_hit  = (STEP_W'(t_reg) == steps_reg);
    assign wk_wrap = !phase_reg && (t_reg != '0) && (idx_reg == start_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        mod_start  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    case (s_axis_tuser)
                        REQ_INIT:
                        begin
                            state_next = S_INIT;
                        end
                        REQ_SHUFFLE:
                        begin
                            if (loaded_reg && !shuf_full && !swap_bad)
                            begin
                                state_next = S_SH_RD_B;
                            end
                            else
                            begin
                                state_next = S_RESP;
                            end
                        end
                        REQ_WALK:
                        begin
                            if (loaded_reg && !start_bad)
                            begin
                                state_next = S_WK_CHK;
                            end
                            else
                            begin
                                state_next = S_RESP;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_INIT:
            begin
                if (init_cnt_reg == AW'(MEM_DEPTH - 1))
                begin
                    state_next = S_RESP;
                end
            end
            S_SH_RD_B:
            begin
                state_next = S_SH_WR_A;
            end
            S_SH_WR_A:
            begin
                state_next = S_SH_WR_B;
            end
            S_SH_WR_B:
            begin
                state_next = S_RESP;
            end
            S_WK_CHK:
            begin
                if (wk_hit)
                begin
                    state_next = S_RESP;
                end
                else if (wk_wrap)
                begin
                    mod_start  = 1'b1;
                    state_next = S_WK_MOD;
                end
                else
                begin
                    state_next = S_WK_WAIT;
                end
            end
            S_WK_WAIT:
            begin
                state_next = S_WK_CHK;
            end
            S_WK_MOD:
            begin
                if (mod_done)
                begin
                    state_next = S_WK_CHK;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Table port control
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = pos_reg[AW-1:0];
        mem_wdata = mem_rdata;
        case (state_reg)
            S_SH_RD_B:
            begin
                mem_raddr = target_reg[AW-1:0];
            end
            S_WK_CHK:
            begin
                mem_raddr = idx_reg[AW-1:0];
            end
            default:
            begin
                mem_raddr = pos_reg[AW-1:0];
            end
        endcase
        case (state_reg)
            S_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = init_cnt_reg;
                mem_wdata = IDX_W'(init_cnt_reg);
            end
            S_SH_WR_A:
            begin
                mem_we    = 1'b1;
                mem_waddr = pos_reg[AW-1:0];
                mem_wdata = mem_rdata;
            end
            S_SH_WR_B:
            begin
                mem_we    = 1'b1;
                mem_waddr = target_reg[AW-1:0];
                mem_wdata = a_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            len_reg     <= LEN_W'(LEN_RST);
            pos_reg     <= '0;
            loaded_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                len_reg <= cfg_len;
            end
            if (state_reg == S_INIT && state_next == S_RESP)
            begin
                loaded_reg <= 1'b1;
                pos_reg    <= '0;
            end
            if (state_reg == S_SH_WR_B)
            begin
                pos_reg <= pos_reg + 1'b1;
            end
            // Hold the result until its transfer, then load the next one
            if (state_reg == S_RESP && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Request payload and walk datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                fin_reg      <= '0;
                status_reg   <= in_status;
                init_cnt_reg <= '0;
                target_reg   <= in_target;
                start_reg    <= in_start;
                idx_reg      <= in_start;
                steps_reg    <= in_steps;
                t_reg        <= '0;
                phase_reg    <= 1'b0;
            end
            S_INIT:
            begin
                init_cnt_reg <= init_cnt_reg + 1'b1;
            end
            S_SH_RD_B:
            begin
                a_reg <= mem_rdata;
            end
            S_WK_CHK:
            begin
                if (wk_hit)
                begin
                    fin_reg <= idx_reg;
                end
            end
            S_WK_WAIT:
            begin
                idx_reg <= mem_rdata;
                t_reg   <= t_reg + 1'b1;
            end
            S_WK_MOD:
            begin
                // Remaining steps after whole laps around the cycle
                if (mod_done)
                begin
                    steps_reg <= STEP_W'(mod_rem);
                    t_reg     <= '0;
                    phase_reg <= 1'b1;
                end
            end
            default:
            begin
                fin_reg <= fin_reg;
            end
        endcase
        if (state_reg == S_RESP && out_free)
        begin
            out_fin_reg    <= fin_reg;
            out_done_reg   <= loaded_reg && shuf_full;
            out_status_reg <= status_reg;
        end
    end

    cpc_ram
        #(
            .WIDTH (IDX_W),
            .DEPTH (MEM_DEPTH)
        )
        u_table
        (
            .clk   (clk),
            .we    (mem_we),
            .waddr (mem_waddr),
            .wdata (mem_wdata),
            .raddr (mem_raddr),
            .rdata (mem_rdata)
        );

    cpc_mod u_mod
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .start     (mod_start),
            .dividend  (steps_reg),
            .divisor   (t_reg),
            .done      (mod_done),
            .remainder (mod_rem)
        );

    // Drive the result stream
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - IDX_W - 1){1'b0}}, out_done_reg, out_fin_reg};
    assign m_axis_tuser  = out_status_reg;

`ifndef NO_ASSERTIONS
    // A rejected request never reports a walk index
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (m_axis_tdata[IDX_W-1:0] == '0))
        else $error("nonzero final index on rejected request");

    // Shuffle completion is only reported on a loaded table
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[IDX_W] |-> loaded_reg)
        else $error("shuffle done without loaded table");

    // The remainder unit never runs with a zero cycle length
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WK_MOD) |-> (t_reg != '0))
        else $error("zero divisor in remainder unit");

    // After the remainder pass the walk stays within the remaining step count
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WK_CHK) && phase_reg |-> (t_reg <= steps_reg[LEN_W-1:0])
            && (steps_reg[STEP_W-1:LEN_W] == '0))
        else $error("walk overran remaining step count");
`endif

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

import cpc_pkg::*;

// One request as the stream carries it
typedef struct packed {
    logic [REQ_W-1:0]  kind;
    logic [IDX_W-1:0]  partner;
    logic [IDX_W-1:0]  start;
    logic [STEP_W-1:0] steps;
} request_t;

// One response as the stream carries it
typedef struct packed {
    logic [IDX_W-1:0]    final_index;
    logic                shuffle_done;
    logic [STATUS_W-1:0] status;
} response_t;

// Mirror of the cycle table: tracks the table, the shuffle position and the length,
// and queues the response each accepted request should produce.
class perm_board;
    logic [IDX_W-1:0] link [IDX_SPAN];
    int unsigned      swap_pos;
    bit               loaded;
    logic [LEN_W-1:0] length_reg;
    response_t        expected_q[$];
    int               errors;

    function new();
        swap_pos   = 0;
        loaded     = 1'b0;
        length_reg = LEN_W'(IDX_SPAN);
        errors     = 0;
        foreach (link[i]) link[i] = '0;
    endfunction

    function void set_length(logic [LEN_W-1:0] v);
        length_reg = v;
    endfunction

    // Clamp the length register into 2..depth
    function int unsigned active_len();
        int unsigned n;
        n = length_reg;
        if (n < 2) n = 2;
        if (n > IDX_SPAN) n = IDX_SPAN;
        return n;
    endfunction

    // Follow the links; once a node repeats, skip whole laps of its cycle
    function logic [IDX_W-1:0] chase(logic [IDX_W-1:0] from, logic [STEP_W-1:0] steps);
        longint           seen_at [IDX_SPAN];
        logic [IDX_W-1:0] at;
        longint           total;
        longint           t;
        longint           rest;
        foreach (seen_at[i]) seen_at[i] = -1;
        total = steps;
        at    = from;
        t     = 0;
        while (t < total) begin
            if (seen_at[at] >= 0) begin
                rest = (total - t) % (t - seen_at[at]);
                while (rest > 0) begin
                    at = link[at];
                    rest--;
                end
                return at;
            end
            seen_at[at] = t;
            at = link[at];
            t++;
        end
        return at;
    endfunction

    // Update the mirror for an accepted request and queue its response
    function void apply_request(request_t r);
        response_t        resp;
        int unsigned      n;
        logic [IDX_W-1:0] held;
        n    = active_len();
        resp = '0;
        case (r.kind)
            REQ_INIT:
            begin
                foreach (link[i]) link[i] = IDX_W'(i);
                swap_pos = 0;
                loaded   = 1'b1;
            end
            REQ_SHUFFLE:
            begin
                if (!loaded)
                    resp.status = ST_NO_INIT;
                else if (swap_pos >= n - 1)
                    resp.status = ST_COMPLETE;
                else if (r.partner < swap_pos + 1 || r.partner > n - 1)
                    resp.status = ST_BAD_SWAP;
                else
                begin
                    held             = link[swap_pos];
                    link[swap_pos]   = link[r.partner];
                    link[r.partner]  = held;
                    swap_pos         = (swap_pos + 1) & ((1 << LEN_W) - 1);
                end
            end
            REQ_WALK:
            begin
                if (!loaded)
                    resp.status = ST_NO_INIT;
                else if (r.start >= n)
                    resp.status = ST_BAD_START;
                else
                    resp.final_index = chase(r.start, r.steps);
            end
            default: ;
        endcase
        resp.shuffle_done = loaded && (swap_pos >= n - 1);
        expected_q.push_back(resp);
    endfunction

    // Compare one output transfer with the oldest queued response
    function void compare_response(logic [OUT_DATA_W-1:0] data, logic [STATUS_W-1:0] st);
        response_t want;
        if (expected_q.size() == 0)
        begin
            $error("response with nothing outstanding: tdata=%h tuser=%0d", data, st);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        if (data[IDX_W-1:0] !== want.final_index)
        begin
            $error("final_index mismatch: expected %0d, actual %0d",
                   want.final_index, data[IDX_W-1:0]);
            errors++;
        end
        if (data[IDX_W] !== want.shuffle_done)
        begin
            $error("shuffle_done mismatch: expected %0d, actual %0d",
                   want.shuffle_done, data[IDX_W]);
            errors++;
        end
        if (st !== want.status)
        begin
            $error("status mismatch: expected %0d, actual %0d", want.status, st);
            errors++;
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module tb_top;

    // Request code the block leaves unused
    localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [LEN_W-1:0]      cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [REQ_W-1:0]      s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]   m_axis_tuser;

    perm_board   board;
    int unsigned src_idle_pct;
    int unsigned stall_pct;

    cyclic_permutation_pointer_chase u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #(200_000_000);
        $display("Verification failed");
        $finish;
    end

    // Stall the output at random and check every response transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
            if (m_axis_tvalid && m_axis_tready)
                board.compare_response(m_axis_tdata, m_axis_tuser);
        end
    end

    // Present one request, hold it until the transfer, then note it
    task automatic issue(input logic [REQ_W-1:0] kind, input logic [IDX_W-1:0] partner,
                         input logic [IDX_W-1:0] start, input logic [STEP_W-1:0] steps);
        request_t r;
        r = '{kind: kind, partner: partner, start: start, steps: steps};
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.kind;
        s_axis_tdata  <= {{(IN_DATA_W - STEP_W - 2*IDX_W){1'b0}}, r.steps, r.start, r.partner};
        do @(posedge clk); while (!s_axis_tready);
        board.apply_request(r);
    endtask

    // Drop valid and wait until every response is back
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_length(input logic [LEN_W-1:0] v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        board.set_length(v);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly short tables; walks around long cycles are slow
    function automatic logic [LEN_W-1:0] pick_length();
        int unsigned d;
        d = $urandom_range(99);
        if (d < 70) return LEN_W'($urandom_range(40, 2));
        if (d < 78) return LEN_W'($urandom_range(1));
        if (d < 85) return LEN_W'(IDX_SPAN);
        if (d < 90) return LEN_W'($urandom_range((1 << LEN_W) - 1, IDX_SPAN + 1));
        return LEN_W'($urandom_range(IDX_SPAN - 1, 41));
    endfunction

    function automatic logic [STEP_W-1:0] pick_steps(int unsigned n);
        int unsigned d;
        d = $urandom_range(99);
        if (d < 25) return STEP_W'($urandom_range(3));
        if (d < 65) return STEP_W'($urandom_range(2 * n + 4));
        return STEP_W'($urandom);
    endfunction

    initial
    begin
        int unsigned      phase;
        int unsigned      sent;
        int unsigned      burst;
        int unsigned      n;
        int unsigned      d;
        logic [REQ_W-1:0] kind;

        board         = new();
        src_idle_pct  = 0;
        stall_pct     = 0;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= REQ_INIT;
        m_axis_tready <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Requests before any init, and the unused code
        issue(REQ_WALK, '0, '0, STEP_W'(5));
        issue(REQ_SHUFFLE, IDX_W'(1), '0, '0);
        issue(REQ_SPARE, '1, '1, '1);

        // Identity table at full length, then partner and walk corners
        issue(REQ_INIT, '0, '0, '0);
        issue(REQ_WALK, '0, '1, '1);
        issue(REQ_WALK, '1, '0, '0);
        issue(REQ_SHUFFLE, '0, '0, '0);
        issue(REQ_SHUFFLE, '1, '0, '0);
        issue(REQ_SHUFFLE, IDX_W'(1), '0, '0);
        issue(REQ_WALK, '0, '0, STEP_W'(1));
        issue(REQ_WALK, '0, IDX_W'(5), '1);

        // Length below range acts as two: bad start, finished shuffle
        write_length('0);
        issue(REQ_WALK, '0, IDX_W'(2), STEP_W'(1));
        issue(REQ_WALK, '0, IDX_W'(1), STEP_W'(3));
        issue(REQ_SHUFFLE, IDX_W'(1), '0, '0);

        // Length above range acts as full depth
        write_length('1);
        issue(REQ_INIT, '1, '1, '1);

        // Shortest table: complete the shuffle and walk the swapped pair
        write_length(LEN_W'(2));
        issue(REQ_SHUFFLE, IDX_W'(2), '0, '0);
        issue(REQ_SHUFFLE, IDX_W'(1), '0, '0);
        issue(REQ_SHUFFLE, IDX_W'(1), '0, '0);
        issue(REQ_WALK, '0, '0, '1);
        issue(REQ_WALK, '0, IDX_W'(1), STEP_W'(2));
        issue(REQ_SPARE, '0, '0, '0);
        issue(REQ_WALK, '0, '1, STEP_W'(1));

        // Random phases: mostly well-formed shuffles and walks, some noise
        phase = 0;
        sent  = 0;
        while (sent < 950)
        begin
            write_length(pick_length());
            case (phase % 5)
                0: begin src_idle_pct = 0;  stall_pct = 0;  end
                1: begin src_idle_pct = 46; stall_pct = 0;  end
                2: begin src_idle_pct = 0;  stall_pct = 46; end
                3: begin src_idle_pct = 11; stall_pct = 11; end
                default: begin src_idle_pct = 0; stall_pct = 0; end
            endcase
            phase++;
            if (!board.loaded || $urandom_range(99) < 65)
            begin
                issue(REQ_INIT, IDX_W'($urandom), IDX_W'($urandom), STEP_W'($urandom));
                sent++;
            end
            burst = $urandom_range(60, 20);
            repeat (burst)
            begin
                n = board.active_len();
                d = $urandom_range(99);
                if (board.loaded && board.swap_pos < n - 1 && d < 50)
                    issue(REQ_SHUFFLE, IDX_W'($urandom_range(n - 1, board.swap_pos + 1)),
                          IDX_W'($urandom), STEP_W'($urandom));
                else if (board.loaded && d < 85)
                    issue(REQ_WALK, IDX_W'($urandom), IDX_W'($urandom_range(n - 1)),
                          pick_steps(n));
                else
                begin
                    kind = REQ_W'($urandom_range(3));
                    issue(kind, IDX_W'($urandom), IDX_W'($urandom), STEP_W'($urandom));
                    if (kind == REQ_SPARE) sent--;
                end
                sent++;
            end
        end

        // Drain and let the block go quiet
        settle();
        repeat (40) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
